### sv/shake_detector_ema_threshold_unit_macros.svh
// ============================================================================
// shake detector assertion macros
// shared property shapes for the concurrent checks of the shake detector
// ============================================================================
`ifndef SHAKE_DETECTOR_EMA_THRESHOLD_UNIT_MACROS_SVH
`define SHAKE_DETECTOR_EMA_THRESHOLD_UNIT_MACROS_SVH

// same-cycle implication, disabled while reset is active
`define SDET_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is active
`define SDET_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/sdet_pkg.sv
// ============================================================================
// sdet_pkg
// shared constants, register codes and types of the shake detector
// ============================================================================
package sdet_pkg;

    // default geometry
    localparam int SAMPLE_BITS_DEF         = 10;
    localparam int LEVEL_FRACTION_BITS_DEF = 8;

    // one lane per accelerometer axis
    localparam int NUM_AXES = 3;

    // q0.16 smoothing weight
    localparam int WEIGHT_BITS = 16;
    localparam int ROUND_HALF  = 1 << (WEIGHT_BITS - 1);

    // reset values, truncated to the level width where used
    localparam logic [WEIGHT_BITS-1:0] WEIGHT_RESET = 16'd3277;
    localparam int THRESHOLD_RESET = 16717;
    localparam int AVERAGE_RESET   = 15034;

    // configuration register indexes
    localparam int CFG_ADDR_BITS = 1;
    localparam logic [CFG_ADDR_BITS-1:0] REG_SMOOTHING_WEIGHT = 1'd0;
    localparam logic [CFG_ADDR_BITS-1:0] REG_SHAKE_THRESHOLD  = 1'd1;

    // status of the iterative root unit
    typedef struct packed {
        logic busy;
        logic done;
    } root_stat_t;

endpackage

### sv/sdet_square_lane.sv
// ============================================================================
// sdet_square_lane
// one axis lane: registered square of a signed sample
// ============================================================================
module sdet_square_lane #(
    parameter int SAMPLE_BITS = sdet_pkg::SAMPLE_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         en,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    output logic [2*SAMPLE_BITS-2:0]     square
);
    import sdet_pkg::*;

    localparam int PROD_BITS = 2 * SAMPLE_BITS;

    logic signed [PROD_BITS-1:0] prod;
    logic [PROD_BITS-2:0]        square_reg;

    // square of a signed value is at most 2^(2n-2), fits without the sign bit
    assign prod = sample * sample;

    always_ff @(posedge aclk) begin
        if (en) begin
            square_reg <= prod[PROD_BITS-2:0];
        end
    end

    assign square = square_reg;

endmodule

### sv/sdet_merge.sv
// ============================================================================
// sdet_merge
// merging stage: registered sum of the per-axis squares
// ============================================================================
module sdet_merge #(
    parameter int SAMPLE_BITS = sdet_pkg::SAMPLE_BITS_DEF
) (
    input  logic                     aclk,
    input  logic                     en,
    input  logic [2*SAMPLE_BITS-2:0] square [sdet_pkg::NUM_AXES],
    output logic [2*SAMPLE_BITS-1:0] sum
);
    import sdet_pkg::*;

    localparam int SUM_BITS = 2 * SAMPLE_BITS;

    logic [SUM_BITS-1:0] sum_next;
    logic [SUM_BITS-1:0] sum_reg;

    always_comb begin
        sum_next = '0;
        for (int i = 0; i < NUM_AXES; i++) begin
            sum_next = sum_next + SUM_BITS'(square[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sum_reg <= sum_next;
        end
    end

    assign sum = sum_reg;

endmodule

### sv/sdet_sqrt.sv
// ============================================================================
// sdet_sqrt
// iterative floor square root, one root bit per cycle
// ============================================================================
module sdet_sqrt #(
    parameter int SAMPLE_BITS = sdet_pkg::SAMPLE_BITS_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [2*SAMPLE_BITS-1:0]   radicand,
    output logic [SAMPLE_BITS-1:0]     root,
    output sdet_pkg::root_stat_t       stat
);
    import sdet_pkg::*;

    localparam int RAD_BITS = 2 * SAMPLE_BITS;
    localparam int REM_BITS = SAMPLE_BITS + 2;
    localparam int CNT_BITS = $clog2(SAMPLE_BITS + 1);

    logic [CNT_BITS-1:0]    cnt_reg;
    logic                   done_reg;
    logic [RAD_BITS-1:0]    rad_reg;
    logic [REM_BITS-1:0]    rem_reg;
    logic [SAMPLE_BITS-1:0] root_reg;

    logic [REM_BITS-1:0]    rem_shift;
    logic [REM_BITS:0]      trial;

    // bring down the next two radicand bits and try root*4+1
    assign rem_shift = {rem_reg[REM_BITS-3:0], rad_reg[RAD_BITS-1 -: 2]};
    assign trial     = {1'b0, rem_shift} - {1'b0, root_reg, 2'b01};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                cnt_reg <= CNT_BITS'(SAMPLE_BITS);
            end else if (cnt_reg != '0) begin
                cnt_reg <= cnt_reg - CNT_BITS'(1);
                if (cnt_reg == CNT_BITS'(1)) begin
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (cnt_reg != '0) begin
            rad_reg <= {rad_reg[RAD_BITS-3:0], 2'b00};
            if (!trial[REM_BITS]) begin
                rem_reg  <= trial[REM_BITS-1:0];
                root_reg <= {root_reg[SAMPLE_BITS-2:0], 1'b1};
            end else begin
                rem_reg  <= rem_shift;
                root_reg <= {root_reg[SAMPLE_BITS-2:0], 1'b0};
            end
        end
    end

    assign root      = root_reg;
    assign stat.busy = (cnt_reg != '0);
    assign stat.done = done_reg;

endmodule

### sv/sdet_blend.sv
// ============================================================================
// sdet_blend
// rounded q0.16 exponential blend of the magnitude into the running level
// ============================================================================
module sdet_blend #(
    parameter int SAMPLE_BITS         = sdet_pkg::SAMPLE_BITS_DEF,
    parameter int LEVEL_FRACTION_BITS = sdet_pkg::LEVEL_FRACTION_BITS_DEF
) (
    input  logic                                          aclk,
    input  logic                                          en,
    input  logic [SAMPLE_BITS-1:0]                        magnitude,
    input  logic [SAMPLE_BITS+LEVEL_FRACTION_BITS-1:0]    average,
    input  logic [sdet_pkg::WEIGHT_BITS-1:0]              weight,
    output logic [SAMPLE_BITS+LEVEL_FRACTION_BITS-1:0]    level
);
    import sdet_pkg::*;

    localparam int LEVEL_BITS = SAMPLE_BITS + LEVEL_FRACTION_BITS;
    localparam int PROD_BITS  = LEVEL_BITS + 1 + WEIGHT_BITS + 1;
    localparam int STEP_BITS  = PROD_BITS - WEIGHT_BITS;

    logic [LEVEL_BITS-1:0]        wide;
    logic signed [LEVEL_BITS:0]   diff;
    logic signed [WEIGHT_BITS:0]  weight_s;
    logic signed [PROD_BITS-1:0]  prod_reg;
    logic signed [PROD_BITS-1:0]  rounded;
    logic signed [STEP_BITS-1:0]  step;
    logic signed [STEP_BITS-1:0]  sum;

    // avg' = avg + floor((w * (wide - avg) + half) / 2^16)
    assign wide     = {magnitude, {LEVEL_FRACTION_BITS{1'b0}}};
    assign diff     = $signed({1'b0, wide}) - $signed({1'b0, average});
    assign weight_s = $signed({1'b0, weight});

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= diff * weight_s;
        end
    end

    assign rounded = prod_reg + $signed(PROD_BITS'(ROUND_HALF));
    assign step    = rounded[PROD_BITS-1:WEIGHT_BITS];
    assign sum     = $signed({2'b00, average}) + step;

    // convex mix stays in range, clamp kept as a guard
    always_comb begin
        if (sum[STEP_BITS-1]) begin
            level = '0;
        end else if (sum[LEVEL_BITS]) begin
            level = '1;
        end else begin
            level = sum[LEVEL_BITS-1:0];
        end
    end

endmodule

### sv/shake_detector_ema_threshold_unit.sv
// ============================================================================
// shake_detector_ema_threshold_unit
// accelerometer magnitude, exponential smoothing and shake threshold
// ============================================================================
// One three-axis sample in, one result out. Each transfer on the s_ side
// carries three signed axis counts; the block squares them in three parallel
// lanes, sums the squares, takes the floor square root as the magnitude,
// blends that magnitude (with LEVEL_FRACTION_BITS fraction bits) into a
// running average with the q0.16 weight in register 0 using round-half-up,
// and flags a shake when the new average is strictly above the threshold in
// register 1. A sample passes the squaring lanes, the merge register, the
// iterative root unit, which resolves one root bit per cycle, and the blend
// product register; the blend step waits until the output register is free.
// The next sample is taken as soon as the previous result has moved into the
// output register, even while that result still waits on m_tready.
// Configuration writes are meant to happen only while no sample is in work.

module shake_detector_ema_threshold_unit #(
    parameter int SAMPLE_BITS         = sdet_pkg::SAMPLE_BITS_DEF,
    parameter int LEVEL_FRACTION_BITS = sdet_pkg::LEVEL_FRACTION_BITS_DEF,
    localparam int LEVEL_BITS   = SAMPLE_BITS + LEVEL_FRACTION_BITS,
    localparam int CFG_BITS     = (LEVEL_BITS > sdet_pkg::WEIGHT_BITS) ?
                                  LEVEL_BITS : sdet_pkg::WEIGHT_BITS,
    localparam int S_TDATA_BITS = ((sdet_pkg::NUM_AXES * SAMPLE_BITS + 7) / 8) * 8,
    localparam int M_TDATA_BITS = ((SAMPLE_BITS + LEVEL_BITS + 7) / 8) * 8
) (
    input  logic                               aclk,
    input  logic                               aresetn,

    // configuration write port
    input  logic                               cfg_we,
    input  logic [sdet_pkg::CFG_ADDR_BITS-1:0] cfg_addr,
    input  logic [CFG_BITS-1:0]                cfg_wdata,

    // sample input
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [S_TDATA_BITS-1:0]            s_tdata,   // accel_x, accel_y, accel_z

    // result output
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [M_TDATA_BITS-1:0]            m_tdata,   // magnitude, smoothed_level
    output logic                               m_tuser    // shake_detected
);
    import sdet_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUM,
        ST_LOAD,
        ST_ROOT,
        ST_MUL,
        ST_BLEND
    } state_t;

    state_t state_reg;

    // configuration registers
    logic [WEIGHT_BITS-1:0] weight_reg;
    logic [LEVEL_BITS-1:0]  thr_reg;

    // running average and output register
    logic [LEVEL_BITS-1:0]  avg_reg;
    logic                   m_tvalid_reg;
    logic [SAMPLE_BITS-1:0] mag_reg;
    logic [LEVEL_BITS-1:0]  lvl_reg;
    logic                   flag_reg;

    // datapath wiring
    logic signed [SAMPLE_BITS-1:0] axis   [NUM_AXES];
    logic [2*SAMPLE_BITS-2:0]      square [NUM_AXES];
    logic [2*SAMPLE_BITS-1:0]      sum;
    logic [SAMPLE_BITS-1:0]        root;
    root_stat_t                    root_stat;
    logic [LEVEL_BITS-1:0]         level_next;

    logic s_xfer;
    logic out_free;
    logic out_load;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_xfer   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign out_load = (state_reg == ST_BLEND) && out_free;

    // one squaring lane per axis, fields packed from the lowest bit up
    for (genvar i = 0; i < NUM_AXES; i++) begin : g_lane
        assign axis[i] = $signed(s_tdata[i*SAMPLE_BITS +: SAMPLE_BITS]);

        sdet_square_lane #(
            .SAMPLE_BITS (SAMPLE_BITS)
        ) u_lane (
            .aclk   (aclk),
            .en     (s_xfer),
            .sample (axis[i]),
            .square (square[i])
        );
    end

    // lanes merge into the sum of squares
    sdet_merge #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_merge (
        .aclk   (aclk),
        .en     (state_reg == ST_SUM),
        .square (square),
        .sum    (sum)
    );

    // magnitude, one bit per cycle
    sdet_sqrt #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (state_reg == ST_LOAD),
        .radicand (sum),
        .root     (root),
        .stat     (root_stat)
    );

    // smoothing: product registered in ST_MUL, level ready in ST_BLEND
    sdet_blend #(
        .SAMPLE_BITS         (SAMPLE_BITS),
        .LEVEL_FRACTION_BITS (LEVEL_FRACTION_BITS)
    ) u_blend (
        .aclk      (aclk),
        .en        (state_reg == ST_MUL),
        .magnitude (root),
        .average   (avg_reg),
        .weight    (weight_reg),
        .level     (level_next)
    );

    // configuration writes; bits above a register's width are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            weight_reg <= WEIGHT_RESET;
            thr_reg    <= LEVEL_BITS'(THRESHOLD_RESET);
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_SMOOTHING_WEIGHT: weight_reg <= cfg_wdata[WEIGHT_BITS-1:0];
                REG_SHAKE_THRESHOLD:  thr_reg    <= cfg_wdata[LEVEL_BITS-1:0];
                default: ;
            endcase
        end
    end

    // sequencer, running average and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            avg_reg      <= LEVEL_BITS'(AVERAGE_RESET);
            m_tvalid_reg <= 1'b0;
            mag_reg      <= '0;
            lvl_reg      <= '0;
            flag_reg     <= 1'b0;
        end else begin
            // drained result, unless a new one replaces it at the same edge
            if (m_tvalid_reg && m_tready && !out_load) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_xfer) begin
                        state_reg <= ST_SUM;
                    end
                end
                ST_SUM:  state_reg <= ST_LOAD;
                ST_LOAD: state_reg <= ST_ROOT;
                ST_ROOT: begin
                    if (root_stat.done) begin
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL:  state_reg <= ST_BLEND;
                ST_BLEND: begin
                    // hold here until the output register can take the result
                    if (out_free) begin
                        avg_reg      <= level_next;
                        m_tvalid_reg <= 1'b1;
                        // output payload, loaded together with m_tvalid
                        mag_reg      <= root;
                        lvl_reg      <= level_next;
                        flag_reg     <= (level_next > thr_reg);
                        state_reg    <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_TDATA_BITS'({lvl_reg, mag_reg});
    assign m_tuser  = flag_reg;

    `include "shake_detector_ema_threshold_unit_macros.svh"

    // one sample in work at a time
    `SDET_ASSERT_NEXT(a_single_item, aclk, aresetn, s_xfer, !s_tready,
        "sample taken while another is in work")

    // the running average moves only when a result is loaded
    `SDET_ASSERT_NEXT(a_avg_hold, aclk, aresetn, !out_load, avg_reg == $past(avg_reg),
        "running average changed without a result transfer")

    // a new result appears only from the blend step
    `SDET_ASSERT_IMPL(a_result_source, aclk, aresetn, $rose(m_tvalid_reg),
        $past(state_reg == ST_BLEND), "result raised outside the blend step")

    // the root unit runs only while the sequencer waits for it
    `SDET_ASSERT_IMPL(a_root_window, aclk, aresetn, root_stat.busy,
        state_reg == ST_ROOT, "root unit busy outside its window")

endmodule

### tb/shake_detector_ema_threshold_unit_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// shake_detector_ema_threshold_unit_tb
// self-checking bench for the accelerometer shake detector
// ============================================================================
// Three-axis samples go in on the s_ stream. Each result on the m_ stream is
// checked against a local model of the block:
//   - magnitude is the floor root of the summed squares
//   - the q0.16 smoothed level is rounded half up
//   - the shake flag compares that level with the threshold
// Directed items come first: field extremes, full and zero weight, masking
// of the high register bits, and the threshold extremes. A long receiver
// hold-off then fills the block and stalls its input. Random phases follow,
// each with a new weight and threshold. Both sides insert random idle gaps.
// ============================================================================

module shake_detector_ema_threshold_unit_tb;

    import sdet_pkg::*;

    // geometry of the default build
    localparam int SAMPLE_W  = SAMPLE_BITS_DEF;
    localparam int FRAC_W    = LEVEL_FRACTION_BITS_DEF;
    localparam int MAG_W     = SAMPLE_W;
    localparam int LEVEL_W   = SAMPLE_W + FRAC_W;
    localparam int CFG_W     = (LEVEL_W > WEIGHT_BITS) ? LEVEL_W : WEIGHT_BITS;
    localparam int S_W       = ((NUM_AXES * SAMPLE_W + 7) / 8) * 8;
    localparam int M_W       = ((MAG_W + LEVEL_W + 7) / 8) * 8;
    localparam int S_PAD     = S_W - NUM_AXES * SAMPLE_W;
    localparam longint LEVEL_MAX = (longint'(1) << LEVEL_W) - 1;

    // cycles from sample transfer to result register
    localparam int LATENCY        = SAMPLE_W + 5;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RANDOM_PHASES  = 10;
    localparam int PHASE_SAMPLES  = 180;

    typedef logic signed [SAMPLE_W-1:0] axis_t;

    typedef struct {
        logic [MAG_W-1:0]   magnitude;
        logic [LEVEL_W-1:0] level;
        logic               shake;
    } shake_result_t;

    // clock, reset and ports
    logic                     aclk      = 1'b0;
    logic                     aresetn   = 1'b0;
    logic                     cfg_we    = 1'b0;
    logic [CFG_ADDR_BITS-1:0] cfg_addr  = '0;
    logic [CFG_W-1:0]         cfg_wdata = '0;
    logic                     s_tvalid  = 1'b0;
    logic                     s_tready;
    logic [S_W-1:0]           s_tdata   = '0;   // accel_x, accel_y, accel_z
    logic                     m_tvalid;
    logic                     m_tready  = 1'b0;
    logic [M_W-1:0]           m_tdata;          // magnitude, smoothed_level
    logic                     m_tuser;          // shake_detected

    // local copy of the block's registers and running average
    logic [WEIGHT_BITS-1:0] model_weight    = WEIGHT_RESET;
    logic [LEVEL_W-1:0]     model_threshold = LEVEL_W'(THRESHOLD_RESET);
    logic [LEVEL_W-1:0]     model_level     = LEVEL_W'(AVERAGE_RESET);

    // results predicted at input transfer, waiting for the output transfer
    shake_result_t pending_results[$];

    int fail_count     = 0;
    int stalled_cycles = 0;
    bit no_idle        = 1'b0;   // both sides run without gaps
    bit hold_request   = 1'b0;   // receiver holds off on its next result

    shake_detector_ema_threshold_unit u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // floor square root of x*x + y*y + z*z, one result bit per pass
    function automatic logic [MAG_W-1:0] vector_magnitude(input axis_t ax, input axis_t ay,
                                                          input axis_t az);
        int unsigned energy;
        int unsigned root;
        int unsigned trial;
        energy = int'(ax) * int'(ax) + int'(ay) * int'(ay) + int'(az) * int'(az);
        root   = 0;
        for (int b = MAG_W - 1; b >= 0; b--) begin
            trial = root | (32'd1 << b);
            if (trial * trial <= energy)
                root = trial;
        end
        return MAG_W'(root);
    endfunction

    // blend the new magnitude into the running average and flag a shake
    function automatic shake_result_t advance_shake_model(input axis_t ax, input axis_t ay,
                                                          input axis_t az);
        shake_result_t r;
        longint        blend;
        r.magnitude = vector_magnitude(ax, ay, az);
        blend = longint'(model_weight) * (longint'(r.magnitude) << FRAC_W)
              + ((longint'(1) << WEIGHT_BITS) - longint'(model_weight)) * longint'(model_level)
              + longint'(ROUND_HALF);
        blend = blend >>> WEIGHT_BITS;
        // a convex mix stays in range, the clamp only mirrors the block
        if (blend > LEVEL_MAX)
            blend = LEVEL_MAX;
        model_level = LEVEL_W'(blend);
        r.level     = model_level;
        r.shake     = (model_level > model_threshold);
        return r;
    endfunction

    // watchdog: no transfer and no register write for too long ends the run
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
            stalled_cycles <= 0;
        else
            stalled_cycles <= stalled_cycles + 1;
        if (stalled_cycles >= WATCHDOG_LIMIT) begin
            $display("shake_detector_ema_threshold_unit test failed");
            $finish;
        end
    end

    // result side: random stalls, the long hold-off on request, field checks
    initial begin : result_monitor
        int            stall;
        shake_result_t want;
        while (!aresetn)
            @(posedge aclk);
        forever begin
            @(negedge aclk);
            if (hold_request) begin
                hold_request = 1'b0;
                stall        = HOLD_CYCLES;
            end else if (no_idle) begin
                stall = 0;
            end else begin
                stall = $urandom_range(0, 5);
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            // transfer happened at this edge
            if (pending_results.size() == 0) begin
                $error("result transfer with no sample outstanding: tdata %h tuser %b",
                       m_tdata, m_tuser);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                if (m_tdata[MAG_W-1:0] !== want.magnitude) begin
                    $error("magnitude: expected %0d, actual %0d",
                           want.magnitude, m_tdata[MAG_W-1:0]);
                    fail_count++;
                end
                if (m_tdata[MAG_W +: LEVEL_W] !== want.level) begin
                    $error("smoothed_level: expected %0d, actual %0d",
                           want.level, m_tdata[MAG_W +: LEVEL_W]);
                    fail_count++;
                end
                if (m_tuser !== want.shake) begin
                    $error("shake_detected: expected %0d, actual %0d", want.shake, m_tuser);
                    fail_count++;
                end
            end
        end
    end

    // one sample transfer; valid stays high afterwards, so back-to-back
    // samples follow without a drop in valid
    task automatic send_sample(input axis_t ax, input axis_t ay, input axis_t az);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 5);
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{S_PAD{1'b0}}, az, ay, ax};
        do @(posedge aclk); while (!s_tready);
        pending_results.push_back(advance_shake_model(ax, ay, az));
    endtask

    // drop valid, wait for every result, then let the pipeline settle
    task automatic settle_pipeline();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (LATENCY + 5) @(negedge aclk);
    endtask

    task automatic write_register(input logic [CFG_ADDR_BITS-1:0] idx,
                                  input logic [CFG_W-1:0] value);
        settle_pipeline();
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        // bits above each register's width are dropped
        if (idx == REG_SMOOTHING_WEIGHT)
            model_weight = value[WEIGHT_BITS-1:0];
        else if (idx == REG_SHAKE_THRESHOLD)
            model_threshold = value[LEVEL_W-1:0];
    endtask

    // field extremes with the reset weight and threshold
    task automatic test_field_extremes();
        send_sample(10'sd0, 10'sd0, 10'sd0);
        send_sample(-10'sd512, -10'sd512, -10'sd512);   // largest magnitude
        send_sample(10'sd511, 10'sd511, 10'sd511);
        send_sample(-10'sd512, 10'sd0, 10'sd0);
        send_sample(10'sd0, 10'sd511, 10'sd0);
        send_sample(10'sd0, 10'sd0, -10'sd512);
        send_sample(10'sd3, 10'sd4, 10'sd0);               // exact root
        send_sample(-10'sd1, -10'sd1, -10'sd1);            // root rounds down
        send_sample(10'sd341, -10'sd342, 10'sd341);        // alternating bits
        send_sample(-10'sd342, 10'sd341, -10'sd342);
        send_sample(10'sd0, 10'sd0, 10'sd64);              // resting on gravity
    endtask

    // full weight keeps only 1/65536 of the old level
    task automatic test_full_weight();
        write_register(REG_SMOOTHING_WEIGHT, CFG_W'(16'hFFFF));
        send_sample(-10'sd512, -10'sd512, -10'sd512);
        send_sample(10'sd0, 10'sd0, 10'sd0);
        send_sample(10'sd100, -10'sd200, 10'sd300);
    endtask

    // zero weight freezes the level
    task automatic test_zero_weight();
        write_register(REG_SMOOTHING_WEIGHT, '0);
        send_sample(10'sd511, 10'sd511, 10'sd511);
        send_sample(10'sd0, 10'sd0, 10'sd0);
    endtask

    // bits above the weight width are masked; threshold at both ends
    task automatic test_register_extremes();
        write_register(REG_SMOOTHING_WEIGHT, 18'h3_19AF);
        write_register(REG_SHAKE_THRESHOLD, '0);
        send_sample(10'sd7, -10'sd9, 10'sd30);
        send_sample(10'sd0, 10'sd0, 10'sd0);
        write_register(REG_SHAKE_THRESHOLD, CFG_W'(LEVEL_MAX));
        send_sample(-10'sd512, -10'sd512, -10'sd512);
        send_sample(10'sd511, -10'sd512, 10'sd511);
    endtask

    // receiver stops for a long stretch while samples keep coming
    task automatic test_output_stall();
        write_register(REG_SMOOTHING_WEIGHT, CFG_W'(WEIGHT_RESET));
        write_register(REG_SHAKE_THRESHOLD, CFG_W'(THRESHOLD_RESET));
        no_idle      = 1'b1;
        hold_request = 1'b1;
        repeat (24)
            send_sample(axis_t'($urandom), axis_t'($urandom), axis_t'($urandom));
        no_idle = 1'b0;
    endtask

    // phases of quiet and shaking runs under new register settings
    task automatic test_random_traffic();
        logic [CFG_W-1:0] weight_word;
        logic [CFG_W-1:0] threshold_word;
        int               sent;
        int               run_left;
        bit               quiet;
        axis_t            ax;
        axis_t            ay;
        axis_t            az;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            weight_word = CFG_W'($urandom);   // high bits random, masked by the block
            case ($urandom_range(0, 5))
                0: weight_word[WEIGHT_BITS-1:0] = '0;
                1: weight_word[WEIGHT_BITS-1:0] = '1;
                2: weight_word[WEIGHT_BITS-1:0] = 16'd1;
                3: weight_word[WEIGHT_BITS-1:0] = 16'($urandom_range(1000, 8000));
                default: ;
            endcase
            case ($urandom_range(0, 5))
                0: threshold_word = '0;
                1: threshold_word = CFG_W'(LEVEL_MAX);
                2: threshold_word = CFG_W'($urandom);
                default: threshold_word = CFG_W'($urandom_range(10000, 150000));
            endcase
            write_register(REG_SMOOTHING_WEIGHT, weight_word);
            write_register(REG_SHAKE_THRESHOLD, threshold_word);
            no_idle  = (phase % 4 == 3);
            run_left = 0;
            quiet    = 1'b0;
            for (sent = 0; sent < PHASE_SAMPLES; sent++) begin
                if (run_left == 0) begin
                    run_left = $urandom_range(4, 30);
                    quiet    = 1'($urandom_range(0, 1));
                end
                run_left--;
                if (quiet) begin
                    // device at rest with small jitter
                    ax = axis_t'(int'($urandom_range(0, 40)) - 20);
                    ay = axis_t'(int'($urandom_range(0, 40)) - 20);
                    az = axis_t'(int'($urandom_range(0, 40)) + 44);
                end else begin
                    ax = axis_t'($urandom);
                    ay = axis_t'($urandom);
                    az = axis_t'($urandom);
                end
                send_sample(ax, ay, az);
            end
        end
        no_idle = 1'b0;
    endtask

    initial begin : stimulus
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_field_extremes();
        test_full_weight();
        test_zero_weight();
        test_register_extremes();
        test_output_stall();
        test_random_traffic();

        settle_pipeline();
        if (fail_count == 0 && pending_results.size() == 0)
            $display("shake_detector_ema_threshold_unit test passed");
        else
            $display("shake_detector_ema_threshold_unit test failed");
        $finish;
    end

endmodule
